[src/hight_pkg.sv]
// Package for the HIGHT encryption core: types, constants and byte functions.
// Used by hight_cfg_if, the key schedule, the round unit and the top level.
// Depends on nothing.
package hight_pkg;

  localparam int BLOCK_W   = 64;
  localparam int KEY_W     = 128;
  localparam int CFG_IDX_W = 8;
  localparam int ROUND_W   = 5;

  localparam logic [ROUND_W-1:0] LAST_ROUND = 5'd31;
  localparam logic [6:0]         DELTA_SEED = 7'h5A;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 8'd1;

  typedef logic [3:0][7:0] hight_sk_t;

  typedef enum logic {
    ST_IDLE,
    ST_ROUND
  } hight_state_t;

  typedef struct packed {
    logic start;
    logic advance;
  } hight_ks_ctrl_t;

  function automatic logic [7:0] rol8(input logic [7:0] x, input logic [2:0] n);
    logic [15:0] d;
    d = {x, x} << n;
    return d[15:8];
  endfunction

  function automatic logic [7:0] f0(input logic [7:0] x);
    return rol8(x, 3'd1) ^ rol8(x, 3'd2) ^ rol8(x, 3'd7);
  endfunction

  function automatic logic [7:0] f1(input logic [7:0] x);
    return rol8(x, 3'd3) ^ rol8(x, 3'd4) ^ rol8(x, 3'd6);
  endfunction

  function automatic logic [7:0] mk_byte(input logic [KEY_W-1:0] key, input logic [3:0] idx);
    return key[{idx, 3'b000} +: 8];
  endfunction

  function automatic logic [6:0] lfsr_next(input logic [6:0] d);
    return {d[3] ^ d[0], d[6:1]};
  endfunction

endpackage

[src/hight_pt_if.sv]
// Plaintext request channel: valid, ready and one 64-bit block.
// Depends on hight_pkg for the block width.
interface hight_pt_if;
  logic                          valid;
  logic                          ready;
  logic [hight_pkg::BLOCK_W-1:0] plaintext;

  modport source (output valid, output plaintext, input ready);
  modport sink (input valid, input plaintext, output ready);
endinterface

[src/hight_ct_if.sv]
// Ciphertext request channel: valid, ready and one 64-bit block.
// Depends on hight_pkg for the block width.
interface hight_ct_if;
  logic                          valid;
  logic                          ready;
  logic [hight_pkg::BLOCK_W-1:0] ciphertext;

  modport source (output valid, output ciphertext, input ready);
  modport sink (input valid, input ciphertext, output ready);
endinterface

[src/hight_cfg_if.sv]
// Configuration write channel: valid, ready, register index and write data.
// Depends on hight_pkg for index and data widths.
interface hight_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [hight_pkg::CFG_IDX_W-1:0] index;
  logic [hight_pkg::BLOCK_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[src/hight_keysched.sv]
// Subkey generator: delta LFSR stepped four times per round and the four
// subkeys of the current round from the master key. Depends on hight_pkg.
module hight_keysched (
  input  logic                               clk,
  input  logic                               rst,
  input  hight_pkg::hight_ks_ctrl_t          ctrl,
  input  logic [hight_pkg::KEY_W-1:0]        key,
  input  logic [hight_pkg::ROUND_W-1:0]      round,
  output hight_pkg::hight_sk_t               sk
);

  logic [6:0]      lfsr;
  logic [3:0][6:0] delta;
  logic [6:0]      lfsr_next4;

  always_comb begin
    delta[0] = lfsr;
    delta[1] = hight_pkg::lfsr_next(delta[0]);
    delta[2] = hight_pkg::lfsr_next(delta[1]);
    delta[3] = hight_pkg::lfsr_next(delta[2]);
    lfsr_next4 = hight_pkg::lfsr_next(delta[3]);
  end

  // subkey 4r+k: block i = r/4, position j = 4*(r%4)+k; byte ((j%8 - i) % 8) + 8*(j/8)
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [2:0] lo;
      lo = {round[0], 2'(k)} - round[4:2];
      sk[k] = hight_pkg::mk_byte(key, {round[1], lo}) + {1'b0, delta[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= hight_pkg::DELTA_SEED;
    end else if (ctrl.start) begin
      lfsr <= hight_pkg::DELTA_SEED;
    end else if (ctrl.advance) begin
      lfsr <= lfsr_next4;
    end
  end

endmodule

[src/hight_round.sv]
// Shared HIGHT round unit: one rotating round, or the last round with the
// final whitening folded in. Depends on hight_pkg for F0, F1 and types.
module hight_round (
  input  logic [hight_pkg::BLOCK_W-1:0] x,
  input  hight_pkg::hight_sk_t          sk,
  input  logic [31:0]                   wk,
  input  logic                          last,
  output logic [hight_pkg::BLOCK_W-1:0] y
);

  logic [7:0][7:0] xb;
  logic [7:0][7:0] yb;
  logic [7:0]      n1, n3, n5, n7;

  assign xb = x;

  always_comb begin
    n1 = xb[1] + (hight_pkg::f1(xb[0]) ^ sk[0]);
    n3 = xb[3] ^ (hight_pkg::f0(xb[2]) + sk[1]);
    n5 = xb[5] + (hight_pkg::f1(xb[4]) ^ sk[2]);
    n7 = xb[7] ^ (hight_pkg::f0(xb[6]) + sk[3]);
    if (last) begin
      yb[0] = xb[0] + wk[7:0];
      yb[1] = n1;
      yb[2] = xb[2] ^ wk[15:8];
      yb[3] = n3;
      yb[4] = xb[4] + wk[23:16];
      yb[5] = n5;
      yb[6] = xb[6] ^ wk[31:24];
      yb[7] = n7;
    end else begin
      yb[0] = n7;
      yb[1] = xb[0];
      yb[2] = n1;
      yb[3] = xb[2];
      yb[4] = n3;
      yb[5] = xb[4];
      yb[6] = n5;
      yb[7] = xb[6];
    end
  end

  assign y = yb;

endmodule

[src/hight_block_encrypt.sv]
// HIGHT-64/128 encryption core top level: key registers, sequencer and
// output register. Depends on hight_pkg, the three channel interfaces,
// hight_keysched and hight_round.
//
//   channel  role    payload
//   cfg      sink    index, data (key_low = 0, key_high = 1)
//   pt       sink    plaintext, 64 bits
//   ct       source  ciphertext, 64 bits
//
// A block is whitened as its request is taken (initial whitening), then makes 32
// passes through the one round unit, the last one with final whitening.
// The result sits in an output register; pt is ready again right after.
// A stalled ct holds the final round until the previous result is taken.
// Reset clears the key, the sequencer and the output valid; no sweep.
module hight_block_encrypt (
  input logic       clk,
  input logic       rst,
  hight_cfg_if.sink cfg,
  hight_pt_if.sink  pt,
  hight_ct_if.source ct
);

  logic [hight_pkg::BLOCK_W-1:0] key_low;
  logic [hight_pkg::BLOCK_W-1:0] key_high;
  logic [hight_pkg::KEY_W-1:0]   key;

  hight_pkg::hight_state_t       state, state_next;
  logic [hight_pkg::ROUND_W-1:0] round;
  logic [hight_pkg::BLOCK_W-1:0] x;
  logic [hight_pkg::BLOCK_W-1:0] x_white;
  logic [hight_pkg::BLOCK_W-1:0] y;
  logic [hight_pkg::BLOCK_W-1:0] result;
  logic                          result_valid;

  logic [7:0][7:0]               pb;
  logic [7:0][7:0]               wb;
  logic                          last;
  logic                          stall;
  logic                          accept;
  logic                          finish;
  hight_pkg::hight_ks_ctrl_t     ks_ctrl;
  hight_pkg::hight_sk_t          sk;

  assign key = {key_high, key_low};

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        hight_pkg::CFG_KEY_LOW:  key_low  <= cfg.data;
        hight_pkg::CFG_KEY_HIGH: key_high <= cfg.data;
        default: ;
      endcase
    end
  end

  // initial whitening with MK12..MK15
  assign pb = pt.plaintext;
  always_comb begin
    wb    = pb;
    wb[0] = pb[0] + hight_pkg::mk_byte(key, 4'd12);
    wb[2] = pb[2] ^ hight_pkg::mk_byte(key, 4'd13);
    wb[4] = pb[4] + hight_pkg::mk_byte(key, 4'd14);
    wb[6] = pb[6] ^ hight_pkg::mk_byte(key, 4'd15);
  end
  assign x_white = wb;

  assign last   = (round == hight_pkg::LAST_ROUND);
  assign stall  = (state == hight_pkg::ST_ROUND) && last && result_valid && !ct.ready;
  assign accept = pt.valid && pt.ready;
  assign finish = (state == hight_pkg::ST_ROUND) && last && !stall;

  always_comb begin
    state_next = state;
    case (state)
      hight_pkg::ST_IDLE:  if (accept) state_next = hight_pkg::ST_ROUND;
      hight_pkg::ST_ROUND: if (finish) state_next = hight_pkg::ST_IDLE;
      default:             state_next = hight_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pt.ready        = 1'b0;
    ks_ctrl.start   = 1'b0;
    ks_ctrl.advance = 1'b0;
    case (state)
      hight_pkg::ST_IDLE: begin
        pt.ready      = 1'b1;
        ks_ctrl.start = pt.valid;
      end
      hight_pkg::ST_ROUND: begin
        ks_ctrl.advance = !stall;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hight_pkg::ST_IDLE;
      round <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        round <= '0;
      end else if (state == hight_pkg::ST_ROUND && !stall) begin
        round <= round + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x <= x_white;
    end else if (state == hight_pkg::ST_ROUND && !stall) begin
      x <= y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish) begin
      result_valid <= 1'b1;
    end else if (ct.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result <= y;
    end
  end

  assign ct.valid      = result_valid;
  assign ct.ciphertext = result;

  hight_keysched u_keysched (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ks_ctrl),
    .key   (key),
    .round (round),
    .sk    (sk)
  );

  // final whitening with MK0..MK3
  hight_round u_round (
    .x    (x),
    .sk   (sk),
    .wk   (key_low[31:0]),
    .last (last),
    .y    (y)
  );

`ifndef SYNTH
  a_start_round0: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == hight_pkg::ST_ROUND) && (round == '0))
    else $error("round counter not cleared on new block");

  a_idle_round0: assert property (@(posedge clk) disable iff (rst)
    (state == hight_pkg::ST_IDLE) |-> (round == '0))
    else $error("round counter nonzero while idle");

  a_finish_result: assert property (@(posedge clk) disable iff (rst)
    finish |=> ct.valid && (state == hight_pkg::ST_IDLE))
    else $error("finished block not presented");

  a_no_early_exit: assert property (@(posedge clk) disable iff (rst)
    (state == hight_pkg::ST_ROUND) && !last |=> (state == hight_pkg::ST_ROUND))
    else $error("left round loop early");
`endif

endmodule

[bench/tb_hight_block_encrypt.sv]
// Self-checking bench for hight_block_encrypt: directed table, then random key phases.
// Each ciphertext is checked against a HIGHT-64/128 predictor kept in this file.
// Depends on hight_pkg and the cfg, pt and ct channel interfaces.
`timescale 1ns / 100ps

module tb_hight_block_encrypt;

  typedef logic [hight_pkg::BLOCK_W-1:0]   block_t;
  typedef logic [hight_pkg::CFG_IDX_W-1:0] reg_idx_t;

  typedef struct packed {
    logic   new_key;
    block_t klo;
    block_t khi;
    block_t blk;
  } dir_row_t;

  localparam logic [6:0] DELTA_INIT   = 7'h5A;
  localparam int         ROT_ROUNDS   = 31;
  localparam int         FINAL_SK     = 124;
  localparam int         DIR_ROWS     = 20;
  localparam int         RAND_PHASES  = 16;
  localparam int         PHASE_BLOCKS = 105;
  localparam int         OUT_HOLD_CYC = 200;
  localparam int         END_WAIT     = 40;
  localparam int         WATCHDOG_NS  = 5_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hight_cfg_if cfg_ch ();
  hight_pt_if  pt_ch ();
  hight_ct_if  ct_ch ();

  hight_block_encrypt uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .pt  (pt_ch),
    .ct  (ct_ch)
  );

  block_t key_lo_now = '0;
  block_t key_hi_now = '0;
  block_t cipher_due [$];
  block_t cipher_exp;
  int     errors     = 0;
  int     blocks_in  = 0;
  int     blocks_out = 0;
  int     key_loads  = 0;
  int     in_stalls  = 0;
  logic   quiet      = 1'b0;
  logic   out_hold   = 1'b0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{1'b0, 64'h0, 64'h0, 64'h0000000000000000},
    '{1'b0, 64'h0, 64'h0, 64'hFFFFFFFFFFFFFFFF},
    '{1'b0, 64'h0, 64'h0, 64'h0123456789ABCDEF},
    '{1'b0, 64'h0, 64'h0, 64'h8000000000000001},
    '{1'b1, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 64'h0000000000000000},
    '{1'b0, 64'h0, 64'h0, 64'hFFFFFFFFFFFFFFFF},
    '{1'b0, 64'h0, 64'h0, 64'h5555555555555555},
    '{1'b1, 64'hFFFFFFFFFFFFFFFF, 64'h0000000000000000, 64'h0000000000000000},
    '{1'b0, 64'h0, 64'h0, 64'hFFFFFFFFFFFFFFFF},
    '{1'b1, 64'h0000000000000000, 64'hFFFFFFFFFFFFFFFF, 64'h0000000000000000},
    '{1'b0, 64'h0, 64'h0, 64'hAAAAAAAAAAAAAAAA},
    '{1'b1, 64'h8899AABBCCDDEEFF, 64'h0011223344556677, 64'h0000000000000000},
    '{1'b1, 64'h7766554433221100, 64'hFFEEDDCCBBAA9988, 64'h7766554433221100},
    '{1'b1, 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, 64'hAAAAAAAAAAAAAAAA},
    '{1'b0, 64'h0, 64'h0, 64'h5555555555555555},
    '{1'b1, 64'h0000000000000000, 64'h0000000000000000, 64'h0000000000000000},
    '{1'b0, 64'h0, 64'h0, 64'h00000000000000FF},
    '{1'b0, 64'h0, 64'h0, 64'hFF00000000000000},
    '{1'b1, 64'h0000000000000001, 64'h8000000000000000, 64'h0000000000000001},
    '{1'b0, 64'h0, 64'h0, 64'h8000000000000000}
  };

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [7:0] spread0(input logic [7:0] v);
    return rotl8(v, 1) ^ rotl8(v, 2) ^ rotl8(v, 7);
  endfunction

  function automatic logic [7:0] spread1(input logic [7:0] v);
    return rotl8(v, 3) ^ rotl8(v, 4) ^ rotl8(v, 6);
  endfunction

  function automatic block_t hight_encrypt(input block_t klo, input block_t khi,
                                           input block_t pblk);
    logic [7:0] mk [16];
    logic [7:0] dseq [128];
    logic [7:0] sk [128];
    logic [7:0] x [8];
    logic [7:0] nx [8];
    logic [6:0] lf;
    block_t     c;
    int         i, j;
    for (i = 0; i < 8; i++) begin
      mk[i]     = klo[8*i +: 8];
      mk[i + 8] = khi[8*i +: 8];
      x[i]      = pblk[8*i +: 8];
    end
    lf = DELTA_INIT;
    for (i = 0; i < 128; i++) begin
      dseq[i] = {1'b0, lf};
      lf = {lf[3] ^ lf[0], lf[6:1]};
    end
    for (i = 0; i < 8; i++) begin
      for (j = 0; j < 8; j++) begin
        sk[16*i + j]     = mk[(j - i) & 7] + dseq[16*i + j];
        sk[16*i + j + 8] = mk[((j - i) & 7) + 8] + dseq[16*i + j + 8];
      end
    end
    // input whitening uses MK12..MK15
    x[0] += mk[12];
    x[2] ^= mk[13];
    x[4] += mk[14];
    x[6] ^= mk[15];
    for (i = 0; i < ROT_ROUNDS; i++) begin
      nx[0] = x[7] ^ (spread0(x[6]) + sk[4*i + 3]);
      nx[1] = x[0];
      nx[2] = x[1] + (spread1(x[0]) ^ sk[4*i]);
      nx[3] = x[2];
      nx[4] = x[3] ^ (spread0(x[2]) + sk[4*i + 1]);
      nx[5] = x[4];
      nx[6] = x[5] + (spread1(x[4]) ^ sk[4*i + 2]);
      nx[7] = x[6];
      x = nx;
    end
    // last round keeps byte order
    x[1] += spread1(x[0]) ^ sk[FINAL_SK];
    x[3] ^= spread0(x[2]) + sk[FINAL_SK + 1];
    x[5] += spread1(x[4]) ^ sk[FINAL_SK + 2];
    x[7] ^= spread0(x[6]) + sk[FINAL_SK + 3];
    x[0] += mk[0];
    x[2] ^= mk[1];
    x[4] += mk[2];
    x[6] ^= mk[3];
    for (i = 0; i < 8; i++)
      c[8*i +: 8] = x[i];
    return c;
  endfunction

  function automatic block_t pick_block();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return block_t'(1) << $urandom_range(0, 63);
      3:       return ~(block_t'(1) << $urandom_range(0, 63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // scoreboard: results are popped before new requests are pushed
  always @(posedge clk) begin
    if (!rst) begin
      if (ct_ch.valid && ct_ch.ready) begin
        blocks_out++;
        if (cipher_due.size() == 0) begin
          $error("ciphertext with no block pending: %h", ct_ch.ciphertext);
          errors++;
        end else begin
          cipher_exp = cipher_due.pop_front();
          if (ct_ch.ciphertext !== cipher_exp) begin
            $error("ciphertext: expected %h, actual %h", cipher_exp, ct_ch.ciphertext);
            errors++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == hight_pkg::CFG_KEY_LOW)
          key_lo_now = cfg_ch.data;
        else if (cfg_ch.index == hight_pkg::CFG_KEY_HIGH)
          key_hi_now = cfg_ch.data;
      end
      if (pt_ch.valid && pt_ch.ready) begin
        cipher_due.push_back(hight_encrypt(key_lo_now, key_hi_now, pt_ch.plaintext));
        blocks_in++;
      end
      if (pt_ch.valid && !pt_ch.ready)
        in_stalls++;
    end
  end

  task automatic send_block(input block_t blk);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      pt_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pt_ch.valid     <= 1'b1;
    pt_ch.plaintext <= blk;
    @(posedge clk);
    while (!pt_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_blocks();
    pt_ch.valid <= 1'b0;
    @(negedge clk);
    while (cipher_due.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input block_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // an unmapped index is slipped in between the two key halves
  task automatic load_key(input block_t lo, input block_t hi);
    reg_idx_t junk;
    junk = reg_idx_t'($urandom_range(2, 255));
    cfg_write(hight_pkg::CFG_KEY_LOW, lo);
    cfg_write(junk, {$urandom, $urandom});
    cfg_write(hight_pkg::CFG_KEY_HIGH, hi);
    cfg_ch.valid <= 1'b0;
    key_loads++;
  endtask

  // ciphertext sink
  initial begin
    int gap;
    ct_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (out_hold) begin
        ct_ch.ready <= 1'b0;
        repeat (OUT_HOLD_CYC) @(negedge clk);
        out_hold = 1'b0;
      end else begin
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
          ct_ch.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      ct_ch.ready <= 1'b1;
      @(posedge clk);
      while (!ct_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int r, ph, n;
    pt_ch.valid     = 1'b0;
    pt_ch.plaintext = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].new_key) begin
        drain_blocks();
        load_key(dir_rows[r].klo, dir_rows[r].khi);
      end
      send_block(dir_rows[r].blk);
    end

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      drain_blocks();
      case (ph)
        0:       load_key('1, '1);
        1:       load_key('0, '0);
        default: load_key({$urandom, $urandom}, {$urandom, $urandom});
      endcase
      quiet = (ph == 2) || ($urandom_range(0, 3) == 0);
      for (n = 0; n < PHASE_BLOCKS; n++) begin
        // long sink hold-off while requests keep coming
        if (ph == 3 && n == 8)
          out_hold = 1'b1;
        if (ph == 5 && n == PHASE_BLOCKS / 2)
          drain_blocks();
        send_block(pick_block());
      end
    end

    drain_blocks();
    repeat (END_WAIT) @(negedge clk);
    $display("Encrypted %0d blocks (%0d returned) under %0d key loads, incl. all-0/all-1 keys.",
             blocks_in, blocks_out, key_loads);
    $display("Random idle on both sides, %0d-cycle sink hold-off, %0d input stall cycles.",
             OUT_HOLD_CYC, in_stalls);
    if (errors == 0)
      $display("PASS hight_block_encrypt");
    else
      $display("FAIL hight_block_encrypt");
    $finish;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("FAIL hight_block_encrypt");
    $finish;
  end

endmodule
